// ----- design/pbi_pkg.sv -----
package pbi_pkg;

  // Configuration register map.
  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_AREA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_A  = 3'd4;

  localparam logic [31:0] DEPTH_RESET = 32'h0001_0000;  // 1.0 in Q16.16

  // Shared multiplier operand widths.
  localparam int unsigned MUL_AW = 34;
  localparam int unsigned MUL_BW = 33;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  // Shared divider widths.
  localparam int unsigned DIV_NW = 64;
  localparam int unsigned DIV_DW = 33;
  localparam int unsigned DIV_CW = 7;

endpackage

// ----- design/pbi_mul.sv -----
module pbi_mul (
  input  logic                                   clk,
  input  logic signed [pbi_pkg::MUL_AW-1:0]      a,
  input  logic signed [pbi_pkg::MUL_BW-1:0]      b,
  output logic signed [pbi_pkg::MUL_PW-1:0]      p
);

  // One signed multiply with its result registered.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- design/pbi_div.sv -----
module pbi_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pbi_pkg::DIV_NW-1:0]     dividend,
  input  logic [pbi_pkg::DIV_DW-1:0]     divisor,
  output logic                           done,
  output logic [pbi_pkg::DIV_NW-1:0]     quotient
);

  logic [pbi_pkg::DIV_DW:0]   rem;
  logic [pbi_pkg::DIV_DW-1:0] dvs;
  logic [pbi_pkg::DIV_CW-1:0] cnt;
  logic                       busy;
  logic [pbi_pkg::DIV_DW:0]   rem_sh;
  logic                       fits;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem[pbi_pkg::DIV_DW-1:0], quotient[pbi_pkg::DIV_NW-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
        cnt      <= pbi_pkg::DIV_CW'(pbi_pkg::DIV_NW);
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
        quotient <= {quotient[pbi_pkg::DIV_NW-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == pbi_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/perspective_barycentric_interp.sv -----
// Channel   Direction  Payload (lowest bits first)
// s_*       in         tuser: new_pixel; tdata: pos_x, pos_y, attr_a, attr_b, attr_c
// m_*       out        tuser: inside_res; tdata: interpolated
// cfg_*     in         cfg_index: register number; cfg_data: 32-bit register value
//
// A reuse item passes through accept, a blend of three shared multiplies, and output. A new pixel
// outside the triangle adds the edge products. A new inside pixel adds the term products, a
// one-bit-per-cycle normalizing shift and three divisions (none if the term sum is zero), plus up
// to three more for the reciprocal depths after reset or a register write. Reset is synchronous
// with no clearing pass. A stalled output holds its result; items and register writes wait for an
// idle sequencer.
module perspective_barycentric_interp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [127:0]                     s_tdata,   // pos_x, pos_y, attr_a, attr_b, attr_c
  input  logic                             s_tuser,   // new_pixel
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata,   // interpolated
  output logic                             m_tuser,   // inside_res
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);

  localparam int unsigned TW = 100;   // width of the exact term products and their sum
  localparam int unsigned EW = 35;    // width of a signed edge value
  localparam int unsigned AW = 66;    // blend accumulator width

  typedef enum logic [3:0] {
    ST_IDLE, ST_EDGE, ST_RECIP, ST_RWAIT, ST_TERM, ST_NORM,
    ST_WDIV, ST_WWAIT, ST_BLEND, ST_OUT
  } state_t;

  state_t state;
  logic [2:0] cnt;
  logic [1:0] idx;

  logic [31:0] cfg_reg [pbi_pkg::NUM_REGS];
  logic        recip_valid;
  logic [31:0] recip [3];

  logic signed [15:0] pos_x, pos_y;
  logic signed [31:0] attr [3];
  logic signed [EW-1:0] edge_val [3];
  logic [TW-1:0] term [3];
  logic [TW-1:0] wsum;
  logic [31:0]   m1hi;
  logic [65:0]   tlo;
  logic [31:0]   weight [3];
  logic          pixel_inside;
  logic signed [AW-1:0] acc;

  logic signed [pbi_pkg::MUL_AW-1:0] mul_a;
  logic signed [pbi_pkg::MUL_BW-1:0] mul_b;
  logic signed [pbi_pkg::MUL_PW-1:0] mul_p;

  logic                         div_start;
  logic [pbi_pkg::DIV_NW-1:0]   div_dividend;
  logic [pbi_pkg::DIV_DW-1:0]   div_divisor;
  logic                         div_done;
  logic [pbi_pkg::DIV_NW-1:0]   div_quot;

  pbi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  pbi_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_quot)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  // Vertex coordinates and differences used by the edge functions.
  logic signed [16:0] ax, ay, bx, by, cx, cy, px, py;
  assign ax = {cfg_reg[pbi_pkg::REG_VERTEX_A][15], cfg_reg[pbi_pkg::REG_VERTEX_A][15:0]};
  assign ay = {cfg_reg[pbi_pkg::REG_VERTEX_A][31], cfg_reg[pbi_pkg::REG_VERTEX_A][31:16]};
  assign bx = {cfg_reg[pbi_pkg::REG_VERTEX_B][15], cfg_reg[pbi_pkg::REG_VERTEX_B][15:0]};
  assign by = {cfg_reg[pbi_pkg::REG_VERTEX_B][31], cfg_reg[pbi_pkg::REG_VERTEX_B][31:16]};
  assign cx = {cfg_reg[pbi_pkg::REG_VERTEX_C][15], cfg_reg[pbi_pkg::REG_VERTEX_C][15:0]};
  assign cy = {cfg_reg[pbi_pkg::REG_VERTEX_C][31], cfg_reg[pbi_pkg::REG_VERTEX_C][31:16]};
  assign px = {pos_x[15], pos_x};
  assign py = {pos_y[15], pos_y};

  logic signed [16:0] ea, eb;
  logic [pbi_pkg::CFG_IDX_W-1:0] depth_sel;
  logic [31:0] depth_cur;
  logic [2:0]  pe;
  logic [1:0]  pe_idx;
  logic signed [EW-1:0] prod_e;
  logic [TW-1:0] tval;
  logic signed [35:0] q;

  assign depth_sel = pbi_pkg::REG_DEPTH_A + pbi_pkg::CFG_IDX_W'(idx);
  assign depth_cur = cfg_reg[depth_sel];
  assign pe        = cnt - 3'd1;
  assign pe_idx    = pe[2:1];
  assign prod_e    = mul_p[EW-1:0];
  assign tval      = TW'(tlo) + (TW'(mul_p[63:0]) << 33);
  assign q         = acc[AW-1:30];

  // Edge operand pairs: each edge is the first product minus the second.
  always_comb begin
    case (cnt)
      3'd0:    begin ea = 17'(cx - px); eb = 17'(by - py); end
      3'd1:    begin ea = 17'(cy - py); eb = 17'(bx - px); end
      3'd2:    begin ea = 17'(cx - ax); eb = 17'(py - ay); end
      3'd3:    begin ea = 17'(cy - ay); eb = 17'(px - ax); end
      3'd4:    begin ea = 17'(px - ax); eb = 17'(by - ay); end
      3'd5:    begin ea = 17'(py - ay); eb = 17'(bx - ax); end
      default: begin ea = '0; eb = '0; end
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_EDGE: begin
        mul_a = pbi_pkg::MUL_AW'(ea);
        mul_b = pbi_pkg::MUL_BW'(eb);
      end
      ST_TERM: begin
        case (cnt)
          3'd0: begin
            mul_a = edge_val[idx][pbi_pkg::MUL_AW-1:0];
            mul_b = {1'b0, cfg_reg[pbi_pkg::REG_INV_AREA]};
          end
          3'd1: begin
            mul_a = {1'b0, mul_p[32:0]};
            mul_b = {1'b0, recip[idx]};
          end
          3'd2: begin
            mul_a = {2'b00, m1hi};
            mul_b = {1'b0, recip[idx]};
          end
          default: ;
        endcase
      end
      ST_BLEND: begin
        if (cnt < 3'd3) begin
          mul_a = {2'b00, weight[cnt[1:0]]};
          mul_b = {attr[cnt[1:0]][31], attr[cnt[1:0]]};
        end
      end
      default: ;
    endcase
  end

  // Divider operands: reciprocal depth or normalized weight.
  always_comb begin
    div_start = 1'b0;
    if (state == ST_RECIP) begin
      div_start    = (depth_cur > 32'd1);
      div_dividend = pbi_pkg::DIV_NW'(64'h1_0000_0000);
      div_divisor  = {1'b0, depth_cur};
    end else begin
      div_start    = (state == ST_WDIV);
      div_dividend = {1'b0, term[idx][32:0], 30'd0};
      div_divisor  = wsum[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      idx          <= '0;
      m_tvalid     <= 1'b0;
      recip_valid  <= 1'b0;
      pixel_inside <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        weight[i] <= '0;
      end
      for (int i = 0; i < int'(pbi_pkg::NUM_REGS); i++) begin
        cfg_reg[i] <= (i >= int'(pbi_pkg::REG_DEPTH_A)) ? pbi_pkg::DEPTH_RESET : 32'd0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Register writes land only while idle; an index past the map is dropped.
      if (cfg_valid && cfg_ready && (cfg_index < pbi_pkg::CFG_IDX_W'(pbi_pkg::NUM_REGS))) begin
        cfg_reg[cfg_index] <= cfg_data;
        recip_valid        <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            pos_x   <= s_tdata[15:0];
            pos_y   <= s_tdata[31:16];
            attr[0] <= s_tdata[63:32];
            attr[1] <= s_tdata[95:64];
            attr[2] <= s_tdata[127:96];
            cnt     <= '0;
            for (int i = 0; i < 3; i++) begin
              edge_val[i] <= '0;
            end
            state <= s_tuser ? ST_EDGE : ST_BLEND;
          end
        end

        // Six products, each accumulated in the cycle after its issue.
        ST_EDGE: begin
          if (cnt != 3'd0) begin
            edge_val[pe_idx] <= pe[0] ? (edge_val[pe_idx] - prod_e)
                                      : (edge_val[pe_idx] + prod_e);
          end
          if (cnt == 3'd6) begin
            cnt <= '0;
            idx <= '0;
            for (int i = 0; i < 3; i++) begin
              weight[i] <= '0;
            end
            state <= ST_BLEND;
          end else begin
            cnt <= cnt + 3'd1;
          end
          if (cnt == 3'd6) begin
            // The last subtraction for edge C lands this cycle, so its sign is taken
            // from the updated value.
            pixel_inside <= !edge_val[0][EW-1] && !edge_val[1][EW-1] &&
                            !(edge_val[2] - prod_e < 0);
            wsum         <= '0;
            if (!edge_val[0][EW-1] && !edge_val[1][EW-1] && !(edge_val[2] - prod_e < 0)) begin
              state <= recip_valid ? ST_TERM : ST_RECIP;
            end
          end
        end

        ST_RECIP: begin
          if (depth_cur <= 32'd1) begin
            recip[idx] <= 32'hFFFF_FFFF;
            if (idx == 2'd2) begin
              idx         <= '0;
              recip_valid <= 1'b1;
              state       <= ST_TERM;
            end else begin
              idx <= idx + 2'd1;
            end
          end else begin
            state <= ST_RWAIT;
          end
        end

        ST_RWAIT: begin
          if (div_done) begin
            recip[idx] <= div_quot[31:0];
            if (idx == 2'd2) begin
              idx         <= '0;
              recip_valid <= 1'b1;
              state       <= ST_TERM;
            end else begin
              idx   <= idx + 2'd1;
              state <= ST_RECIP;
            end
          end
        end

        // Term = edge * inverse area * reciprocal depth, the last product in two halves.
        ST_TERM: begin
          cnt <= cnt + 3'd1;
          case (cnt)
            3'd1: m1hi <= mul_p[64:33];
            3'd2: tlo  <= mul_p[65:0];
            3'd3: begin
              term[idx] <= tval;
              wsum      <= wsum + tval;
              cnt       <= '0;
              if (idx == 2'd2) begin
                idx   <= '0;
                state <= ST_NORM;
              end else begin
                idx <= idx + 2'd1;
              end
            end
            default: ;
          endcase
        end

        // Shift the sum and the terms together until the sum fits in 33 bits; a zero sum goes straight to the blend.
        ST_NORM: begin
          if (wsum == '0) begin
            cnt   <= '0;
            state <= ST_BLEND;
          end else if (|wsum[TW-1:33]) begin
            wsum <= wsum >> 1;
            for (int i = 0; i < 3; i++) begin
              term[i] <= term[i] >> 1;
            end
          end else begin
            idx   <= '0;
            state <= ST_WDIV;
          end
        end

        ST_WDIV: begin
          state <= ST_WWAIT;
        end

        ST_WWAIT: begin
          if (div_done) begin
            weight[idx] <= div_quot[31:0];
            if (idx == 2'd2) begin
              cnt   <= '0;
              state <= ST_BLEND;
            end else begin
              idx   <= idx + 2'd1;
              state <= ST_WDIV;
            end
          end
        end

        // Weighted sum with the rounding half added up front.
        ST_BLEND: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd0) begin
            acc <= AW'(64'sh2000_0000);
          end else begin
            acc <= acc + mul_p[AW-1:0];
          end
          if (cnt == 3'd3) begin
            state <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            if (!q[35] && (|q[34:31])) begin
              m_tdata <= 32'h7FFF_FFFF;
            end else if (q[35] && !(&q[34:31])) begin
              m_tdata <= 32'h8000_0000;
            end else begin
              m_tdata <= q[31:0];
            end
            m_tuser  <= pixel_inside;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
